FILE: sv/bounded_linked_list_engine_unit_defines.svh
// Assertion macros for the port-level checker of the linked list engine.
// No dependencies; include once per compilation unit.
`ifndef BOUNDED_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and ignored while aresetn is low.
`define BLL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and ignored while aresetn is low.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bll_pkg.sv
// Shared types and codes for the bounded linked list engine.
// No dependencies.
package bll_pkg;

    // Request kinds; the fourth code is a no-op that only reports status.
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_REMOVE     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WR,
        ST_INS_TAIL,
        ST_RM_CHK,
        ST_RM_FREE,
        ST_DONE
    } state_t;

    // Strobes from the sequencer to the entry store.
    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic link_we;
    } store_ctrl_t;

endpackage

FILE: sv/bll_store.sv
// Entry store of the linked list engine: value memory and link memory.
// Depends on bll_pkg for the control struct.
module bll_store #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bll_pkg::store_ctrl_t         ctrl,
    input  logic [$clog2(CAPACITY)-1:0]  rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]  wr_addr,
    input  logic [31:0]                  val_wdata,
    input  logic [$clog2(CAPACITY)-1:0]  link_wdata,
    output logic [31:0]                  val_rdata,
    output logic [$clog2(CAPACITY)-1:0]  link_rdata
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    logic [31:0]   values_mem [CAPACITY];
    logic [IW-1:0] links_mem  [CAPACITY];

    logic [31:0]   val_q_reg;
    logic [IW-1:0] link_q_reg;
    logic [IW-1:0] rd_addr_reg;

    // Entries at or above the high-water mark have never had their link written.
    // Their link is the reset chain: the next index, wrapping to zero at the end.
    logic [CW-1:0] hw_reg;
    logic [CW-1:0] hw_next;

    always_ff @(posedge aclk) begin
        if (ctrl.val_we) begin
            values_mem[wr_addr] <= val_wdata;
        end
        if (ctrl.link_we) begin
            links_mem[wr_addr] <= link_wdata;
        end
        if (ctrl.rd_en) begin
            val_q_reg   <= values_mem[rd_addr];
            link_q_reg  <= links_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_comb begin
        hw_next = hw_reg;
        if (ctrl.link_we && (CW'(wr_addr) == hw_reg)) begin
            hw_next = hw_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= '0;
        end else begin
            hw_reg <= hw_next;
        end
    end

    assign val_rdata = val_q_reg;

    always_comb begin
        if (CW'(rd_addr_reg) < hw_reg) begin
            link_rdata = link_q_reg;
        end else if (rd_addr_reg == LAST_IDX) begin
            link_rdata = '0;
        end else begin
            link_rdata = rd_addr_reg + 1'b1;
        end
    end

endmodule

FILE: sv/bounded_linked_list_engine_unit.sv
// Steps: an insert reads the free entry's link, then writes the entry (ST_INS_WR) and, for a
// back insert into a non-empty list, patches the old tail (ST_INS_TAIL); a refused insert, the
// status-only code and a remove on an empty list go straight to ST_DONE. A remove checks each
// entry visited (ST_RM_CHK) while walking the link memory, then frees a match (ST_RM_FREE).
// Throughput: one transaction at a time; the next is accepted once the result is registered.
// Reset (aresetn, synchronous, active low) empties the list without a clearing pass.
// Depends on bll_pkg and bll_store.
module bounded_linked_list_engine_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [31:0] s_item_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [6:0]         m_element_count,
    output logic               m_list_empty,
    output logic               m_value_found,
    output logic               m_insert_rejected
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    // Sequencer state.
    bll_pkg::state_t state_reg, state_next;

    // List bookkeeping. head and tail mean nothing while the count is zero.
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] free_reg, free_next;
    logic [CW-1:0] count_reg, count_next;

    // The transaction being worked on.
    logic [1:0]         kind_reg, kind_next;
    logic signed [31:0] value_reg, value_next;
    logic               found_reg, found_next;
    logic               rejected_reg, rejected_next;

    // Walk position for a remove; cur also carries the new entry index for inserts.
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic          at_head_reg, at_head_next;
    logic [CW-1:0] steps_reg, steps_next;

    // Result register, which lets a finished result wait while the next transaction starts.
    logic       m_valid_reg, m_valid_next;
    logic [6:0] m_count_reg, m_count_next;
    logic       m_empty_reg, m_empty_next;
    logic       m_found_reg, m_found_next;
    logic       m_rejected_reg, m_rejected_next;

    // Entry store interface.
    bll_pkg::store_ctrl_t store_ctrl;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [31:0]   val_wdata;
    logic [IW-1:0] link_wdata;
    logic [31:0]   val_rdata;
    logic [IW-1:0] link_rdata;

    logic          s_fire;
    logic          out_free;
    logic          hit;
    logic [CW+6:0] count_ext;

    assign s_ready  = (state_reg == bll_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = (val_rdata == value_reg);

    bll_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (store_ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .val_wdata  (val_wdata),
        .link_wdata (link_wdata),
        .val_rdata  (val_rdata),
        .link_rdata (link_rdata)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bll_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_kind) inside
                        bll_pkg::KIND_PUSH_FRONT, bll_pkg::KIND_PUSH_BACK: begin
                            state_next = (count_reg == CAP_COUNT) ? bll_pkg::ST_DONE
                                                                  : bll_pkg::ST_INS_WR;
                        end
                        bll_pkg::KIND_REMOVE: begin
                            state_next = (count_reg == '0) ? bll_pkg::ST_DONE
                                                           : bll_pkg::ST_RM_CHK;
                        end
                        default: begin
                            state_next = bll_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bll_pkg::ST_INS_WR: begin
                // A back insert into a non-empty list still has to patch the old tail.
                if (kind_reg == bll_pkg::KIND_PUSH_BACK && count_reg != '0) begin
                    state_next = bll_pkg::ST_INS_TAIL;
                end else begin
                    state_next = bll_pkg::ST_DONE;
                end
            end
            bll_pkg::ST_INS_TAIL: begin
                state_next = bll_pkg::ST_DONE;
            end
            bll_pkg::ST_RM_CHK: begin
                if (hit) begin
                    state_next = bll_pkg::ST_RM_FREE;
                end else if (steps_reg + 1'b1 == count_reg) begin
                    state_next = bll_pkg::ST_DONE;
                end
            end
            bll_pkg::ST_RM_FREE: begin
                state_next = bll_pkg::ST_DONE;
            end
            bll_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bll_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bll_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory strobes for each state.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        value_next    = value_reg;
        found_next    = found_reg;
        rejected_next = rejected_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        at_head_next  = at_head_reg;
        steps_next    = steps_reg;

        store_ctrl = '0;
        rd_addr    = cur_reg;
        wr_addr    = cur_reg;
        val_wdata  = value_reg;
        link_wdata = '0;

        unique case (state_reg)
            bll_pkg::ST_IDLE: begin
                if (s_fire) begin
                    kind_next     = s_kind;
                    value_next    = s_item_value;
                    found_next    = 1'b0;
                    rejected_next = 1'b0;
                    unique case (s_kind) inside
                        bll_pkg::KIND_PUSH_FRONT, bll_pkg::KIND_PUSH_BACK: begin
                            if (count_reg == CAP_COUNT) begin
                                rejected_next = 1'b1;
                            end else begin
                                // Fetch the link of the first free entry.
                                store_ctrl.rd_en = 1'b1;
                                rd_addr          = free_reg;
                            end
                        end
                        bll_pkg::KIND_REMOVE: begin
                            if (count_reg != '0) begin
                                store_ctrl.rd_en = 1'b1;
                                rd_addr          = head_reg;
                                cur_next         = head_reg;
                                prev_next        = '0;
                                at_head_next     = 1'b1;
                                steps_next       = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bll_pkg::ST_INS_WR: begin
                // Take the free entry, store the value and set its link.
                store_ctrl.val_we  = 1'b1;
                store_ctrl.link_we = 1'b1;
                wr_addr            = free_reg;
                cur_next           = free_reg;
                free_next          = link_rdata;
                count_next         = count_reg + 1'b1;
                if (count_reg == '0) begin
                    link_wdata = '0;
                    head_next  = free_reg;
                    tail_next  = free_reg;
                end else if (kind_reg == bll_pkg::KIND_PUSH_FRONT) begin
                    link_wdata = head_reg;
                    head_next  = free_reg;
                end else begin
                    link_wdata = '0;
                end
            end
            bll_pkg::ST_INS_TAIL: begin
                store_ctrl.link_we = 1'b1;
                wr_addr            = tail_reg;
                link_wdata         = cur_reg;
                tail_next          = cur_reg;
            end
            bll_pkg::ST_RM_CHK: begin
                if (hit) begin
                    found_next = 1'b1;
                    count_next = count_reg - 1'b1;
                    // Bypass the matched entry.
                    if (at_head_reg) begin
                        head_next = link_rdata;
                    end else begin
                        store_ctrl.link_we = 1'b1;
                        wr_addr            = prev_reg;
                        link_wdata         = link_rdata;
                    end
                    if (cur_reg == tail_reg) begin
                        tail_next = at_head_reg ? '0 : prev_reg;
                    end
                    if (count_reg == CW'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end else if (steps_reg + 1'b1 != count_reg) begin
                    // Follow the link straight from the read data to the next read.
                    store_ctrl.rd_en = 1'b1;
                    rd_addr          = link_rdata;
                    prev_next        = cur_reg;
                    cur_next         = link_rdata;
                    at_head_next     = 1'b0;
                    steps_next       = steps_reg + 1'b1;
                end
            end
            bll_pkg::ST_RM_FREE: begin
                // Return the unlinked entry to the front of the free list.
                store_ctrl.link_we = 1'b1;
                wr_addr            = cur_reg;
                link_wdata         = free_reg;
                free_next          = cur_reg;
            end
            bll_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // The count port is seven bits wide whatever the capacity.
    assign count_ext = {7'b0, count_reg};

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_count_next    = m_count_reg;
        m_empty_next    = m_empty_reg;
        m_found_next    = m_found_reg;
        m_rejected_next = m_rejected_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == bll_pkg::ST_DONE && out_free) begin
            m_valid_next    = 1'b1;
            m_count_next    = count_ext[6:0];
            m_empty_next    = (count_reg == '0);
            m_found_next    = found_reg;
            m_rejected_next = rejected_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bll_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            free_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        found_reg      <= found_next;
        rejected_reg   <= rejected_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        at_head_reg    <= at_head_next;
        steps_reg      <= steps_next;
        m_count_reg    <= m_count_next;
        m_empty_reg    <= m_empty_next;
        m_found_reg    <= m_found_next;
        m_rejected_reg <= m_rejected_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_element_count   = m_count_reg;
    assign m_list_empty      = m_empty_reg;
    assign m_value_found     = m_found_reg;
    assign m_insert_rejected = m_rejected_reg;

endmodule

FILE: sv/bll_chk.sv
// Port-level checker for the linked list engine, bound to the top level below.
// Depends on bounded_linked_list_engine_unit_defines.svh for the assertion macros.
`include "bounded_linked_list_engine_unit_defines.svh"

module bll_chk #(
    parameter int unsigned CAPACITY = 64
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [6:0]         m_element_count,
    input logic               m_list_empty,
    input logic               m_value_found,
    input logic               m_insert_rejected
);

    logic       out_stall;
    logic [9:0] result_bits;
    logic       empty_ok;
    logic       reject_seen;
    logic       reject_ok;

    assign out_stall   = m_valid && !m_ready;
    assign result_bits = {m_element_count, m_list_empty, m_value_found, m_insert_rejected};
    // The empty flag agrees with the count whenever the count fits the port.
    assign empty_ok    = (CAPACITY >= 128) || (m_list_empty == (m_element_count == 7'd0));
    assign reject_seen = m_valid && m_insert_rejected;
    assign reject_ok   = !m_list_empty && !m_value_found;

    // A result that waits must not change.
    `BLL_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(result_bits), "result not held")

    // The engine works on one transaction at a time.
    `BLL_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "accepted back to back")

    `BLL_ASSERT_NOW(a_empty_count, m_valid, empty_ok, "empty flag disagrees with count")

    // A rejected insert means a full list, which is never empty.
    `BLL_ASSERT_NOW(a_reject_full, reject_seen, reject_ok, "inconsistent reject flags")

endmodule

bind bounded_linked_list_engine_unit bll_chk #(
    .CAPACITY (CAPACITY)
) u_bll_chk (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_element_count   (m_element_count),
    .m_list_empty      (m_list_empty),
    .m_value_found     (m_value_found),
    .m_insert_rejected (m_insert_rejected)
);
